// ===== sv/sbda_pkg.sv =====
// shared types and constants for the signed binary to decimal ascii converter
// no dependencies
`default_nettype none

package sbda_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int DIGITS         = (VALUE_BITS * 3) / 10 + 1;
   localparam int BCD_BITS       = DIGITS * 4;
   localparam int BIT_CNT_BITS   = $clog2(VALUE_BITS);
   localparam int DIG_CNT_BITS   = $clog2(DIGITS + 1);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CHAR_BITS      = 6;

   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 6'd45;

   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_SKIP,
      BACK_SIGN,
      BACK_DIGITS
   } back_state_type;

endpackage

`default_nettype wire

// ===== sv/sbda_front.sv =====
// front part: splits an incoming word into sign and unsigned magnitude
// depends on sbda_pkg
`default_nettype none

module sbda_front
   import sbda_pkg::*;
(
   input  wire logic signed [VALUE_BITS-1:0] value,
   output item_type                          item
);

   logic [VALUE_BITS-1:0] value_u;
   logic                  neg;

   always_comb begin
      value_u  = value;
      neg      = value_u[VALUE_BITS-1];
      item.neg = neg;
      item.mag = (value_u ^ {VALUE_BITS{neg}}) + VALUE_BITS'(neg);
   end

endmodule

`default_nettype wire

// ===== sv/sbda_queue.sv =====
// short queue of classified words between front and back parts
// depends on sbda_pkg
`default_nettype none

module sbda_queue
   import sbda_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output queue_head_type head
);

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_BITS-1:0] next_ptr(
      input logic [QUEUE_PTR_BITS-1:0] ptr
   );
      if (ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
      head.valid = (count_ff != '0);
      head.item  = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sbda_back.sv =====
// back part: shift-and-add-3 binary to bcd, leading zero skip, character output
// depends on sbda_pkg
`default_nettype none

module sbda_back
   import sbda_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire queue_head_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [CHAR_BITS-1:0] rsp_char_code,
   output logic                 rsp_last
);

   back_state_type          state_ff, state_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [BCD_BITS-1:0]     bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]     bcd_adj;
   logic                    neg_ff, neg_in;
   logic [BIT_CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_BITS-1:0] dig_cnt_ff, dig_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]    rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [3:0]              top_digit;
   logic                    final_digit;

   // add 3 to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                         : bcd_ff[i*4 +: 4];
      end
   end

   assign top_digit   = bcd_ff[BCD_BITS-1 -: 4];
   assign final_digit = (dig_cnt_ff == DIG_CNT_BITS'(1));

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               neg_in     = head.item.neg;
               bin_in     = head.item.mag;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_BITS'(VALUE_BITS - 1);
               state_in   = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            bin_in     = {bin_ff[VALUE_BITS-2:0], 1'b0};
            dig_cnt_in = DIG_CNT_BITS'(DIGITS);
            if (bit_cnt_ff == '0) begin
               state_in = BACK_SKIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         BACK_SKIP: begin
            if (top_digit == 4'd0 && !final_digit) begin
               bcd_in     = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = neg_ff ? BACK_SIGN : BACK_DIGITS;
            end
         end
         BACK_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CH_MINUS;
            state_in     = BACK_DIGITS;
         end
         BACK_DIGITS: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CH_ZERO + CHAR_BITS'(top_digit);
            rsp_last_in  = final_digit;
            bcd_in       = {bcd_ff[BCD_BITS-5:0], 4'd0};
            dig_cnt_in   = dig_cnt_ff - 1'b1;
            if (final_digit) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_DIGITS |-> top_digit <= 4'd9)
      else $error("bcd digit out of range");

   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_SIGN |-> neg_ff)
      else $error("minus sign for a non-negative word");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |=> !rsp_valid_ff)
      else $error("character right after last of word");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== sv/signed_binary_to_decimal_ascii.sv =====
// top level: signed binary word to decimal ascii characters
// depends on sbda_pkg, sbda_front, sbda_queue, sbda_back
// each word is popped from the queue, converted by the 32-step bcd shift loop, stripped of
//   leading zero digits and sent as an optional minus sign followed by its digits, the last
//   one flagged; the queue takes new words while the back part is still busy with an earlier one
// busy is high while the two-entry queue is full; results cannot be stalled
// reset clears the queue, the back part state machine and the strobe
`default_nettype none

module signed_binary_to_decimal_ascii
   import sbda_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output logic                              rsp_valid,
   output logic [CHAR_BITS-1:0]              rsp_char_code,
   output logic                              rsp_last
);

   item_type       front_item;
   queue_head_type head;
   logic           full;
   logic           pop;

   sbda_front u_front (
      .value (req_value),
      .item  (front_item)
   );

   sbda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !full),
      .push_item (front_item),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

   sbda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   assign busy = full;

endmodule

`default_nettype wire
